### rtl/rgbmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbmf_pkg
// Shared constants, types and small helper functions for the median filter.
// ----------------------------------------------------------------------------
package rgbmf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int ROW_LIMIT  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(ROW_LIMIT);
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int SPAN       = 3;
  localparam int SLOT_W     = 2;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam int DQ_DEPTH   = 4;
  localparam int OQ_DEPTH   = 8;
  // room needed in the result queue for everything in flight plus one issue
  localparam int CREDIT_MAX = OQ_DEPTH - 3;

  localparam int REG_SEL_BIT = 2;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0] trio_t;   // [0] min, [1] middle, [2] max; also [2] red .. [0] blue

  // run of results released by one pixel
  typedef struct packed {
    logic [COL_W-1:0]  x0;
    logic [COL_W-1:0]  x1;
    logic [ROW_W-1:0]  y0;
    logic [ROW_W-1:0]  y1;
    logic [SLOT_W-1:0] slot;  // line store slot of row y0
  } desc_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(SPAN - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    return (s == '0) ? SLOT_W'(SPAN - 1) : s - 1'b1;
  endfunction

  // effective size minus one: zero acts as one, large values saturate
  function automatic logic [COL_W-1:0] dim_m1(input logic [DIM_W-1:0] v,
                                              input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] e;
    e = v;
    if (v == '0) e = DIM_W'(1);
    if (v > lim) e = lim;
    return COL_W'(e - 1'b1);
  endfunction

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
    trio_t s;
    s[0] = min2(min2(a, b), c);
    s[2] = max2(max2(a, b), c);
    s[1] = med3(a, b, c);
    return s;
  endfunction

endpackage
`default_nettype wire

### rtl/rgbmf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbmf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rgbmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/rgbmf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbmf_front
// Config registers, raster position, line store write and release decode.
// ----------------------------------------------------------------------------
module rgbmf_front import rgbmf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pix_t              in_red,
  input  wire pix_t              in_green,
  input  wire pix_t              in_blue,
  input  wire logic              q_full,
  input  wire logic              back_busy,
  output logic                   push,
  output desc_t                  push_desc,
  output logic      [SPAN-1:0]   wr_en,
  output logic      [COL_W-1:0]  wr_addr,
  output logic      [RGB_W-1:0]  wr_data,
  output logic      [COL_W-1:0]  w_m1,
  output logic      [ROW_W-1:0]  h_m1
);

  logic [DIM_W-1:0]  width_raw;
  logic [DIM_W-1:0]  height_raw;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [SLOT_W-1:0] slot;
  logic              cfg_wr;
  logic              accept;
  logic              hx;
  logic              hy;

  assign cfg_wr = psel && penable && pwrite;
  assign w_m1   = dim_m1(width_raw, DIM_W'(MAX_WIDTH));
  assign h_m1   = ROW_W'(dim_m1(height_raw, DIM_W'(ROW_LIMIT)));
  assign prdata = (paddr[REG_SEL_BIT] == REG_HEIGHT) ?
                  {(DATA_W-DIM_W)'(0), height_raw} : {(DATA_W-DIM_W)'(0), width_raw};

  // a new row only starts once the back end has finished the previous one
  assign in_stall = q_full || ((col == '0) && back_busy);
  assign accept   = in_valid && !in_stall;

  assign wr_en   = accept ? (SPAN'(1) << slot) : '0;
  assign wr_addr = col;
  assign wr_data = {in_red, in_green, in_blue};

  always_comb begin
    hx = 1'b0;
    push_desc.x0 = col;
    push_desc.x1 = col;
    if (col == w_m1) begin
      hx = 1'b1;
      push_desc.x1 = w_m1;
      push_desc.x0 = (w_m1 != '0) ? w_m1 - 1'b1 : '0;
    end else if (col != '0) begin
      hx = 1'b1;
      push_desc.x0 = col - 1'b1;
      push_desc.x1 = col - 1'b1;
    end
    hy = 1'b0;
    push_desc.y0 = row;
    push_desc.y1 = row;
    if (row == h_m1) begin
      hy = 1'b1;
      push_desc.y1 = h_m1;
      push_desc.y0 = (h_m1 != '0) ? h_m1 - 1'b1 : '0;
    end else if (row != '0) begin
      hy = 1'b1;
      push_desc.y0 = row - 1'b1;
      push_desc.y1 = row - 1'b1;
    end
    push_desc.slot = (row == '0) ? slot : slot_dec(slot);
  end

  assign push = accept && hx && hy;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_raw  <= WIDTH_RESET;
      height_raw <= HEIGHT_RESET;
      col        <= '0;
      row        <= '0;
      slot       <= '0;
    end else if (cfg_wr) begin
      if (paddr[REG_SEL_BIT] == REG_HEIGHT) begin
        height_raw <= pwdata[DIM_W-1:0];
      end else begin
        width_raw <= pwdata[DIM_W-1:0];
      end
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (accept) begin
      if (col == w_m1) begin
        col <= '0;
        if (row == h_m1) begin
          row  <= '0;
          slot <= '0;
        end else begin
          row  <= row + 1'b1;
          slot <= slot_inc(slot);
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/rgbmf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbmf_queue
// Short FIFO of release runs between the front and back ends.
// ----------------------------------------------------------------------------
module rgbmf_queue import rgbmf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire desc_t push_desc,
  input  wire logic  pop,
  output desc_t      head,
  output logic       full,
  output logic       empty
);

  localparam int PW = $clog2(DQ_DEPTH);

  desc_t       mem [DQ_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   cnt;

  assign head  = mem[rp];
  assign full  = (cnt == (PW+1)'(DQ_DEPTH));
  assign empty = (cnt == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

### rtl/rgbmf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbmf_back
// Walks release runs, reads window columns, sorts and queues the results.
// ----------------------------------------------------------------------------
module rgbmf_back import rgbmf_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_empty,
  input  wire desc_t                       head,
  output logic                             q_pop,
  output logic                             active,
  input  wire logic [COL_W-1:0]            w_m1,
  input  wire logic [ROW_W-1:0]            h_m1,
  output logic      [COL_W-1:0]            raddr,
  input  wire logic [SPAN-1:0][RGB_W-1:0]  rdata,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output pix_t                             out_red,
  output pix_t                             out_green,
  output pix_t                             out_blue,
  output logic      [COL_W-1:0]            out_col,
  output logic      [ROW_W-1:0]            out_row,
  output logic                             last_of_run
);

  typedef struct packed {
    logic              valid;
    logic              fin;
    logic              last;
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
    logic [SLOT_W-1:0] sm;
    logic [SLOT_W-1:0] sy;
    logic [SLOT_W-1:0] sp;
  } tag_t;

  typedef struct packed {
    pix_t             r;
    pix_t             g;
    pix_t             b;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } res_t;

  localparam int OPW = $clog2(OQ_DEPTH);

  // run walker
  desc_t             cur;
  logic [COL_W-1:0]  cur_x;
  logic [ROW_W-1:0]  cur_y;
  logic [1:0]        k;
  logic [COL_W-1:0]  prev_x;
  logic [ROW_W-1:0]  prev_y;
  logic              prev_valid;

  desc_t             src;
  logic [COL_W-1:0]  sx;
  logic [ROW_W-1:0]  sy;
  logic [1:0]        sk;
  logic              have;
  logic              fast;
  logic              fin;
  logic              go;
  logic              last_job;
  logic [COL_W-1:0]  xl;
  logic [COL_W-1:0]  xr;
  logic              credit_ok;

  tag_t              t1;
  logic              t2_fin;
  logic              t2_last;
  logic [COL_W-1:0]  t2_x;
  logic [ROW_W-1:0]  t2_y;
  trio_t             win [3][3];   // [column][channel], columns sorted on arrival
  trio_t             pm;
  trio_t             pyv;
  trio_t             pp;
  trio_t             nsort [3];
  trio_t             med;

  res_t              oq [OQ_DEPTH];
  logic [OPW-1:0]    owp;
  logic [OPW-1:0]    orp;
  logic [OPW:0]      ocnt;
  logic              opop;
  res_t              ohead;

  assign have = active || !q_empty;
  assign src  = active ? cur : head;
  assign sx   = active ? cur_x : head.x0;
  assign sy   = active ? cur_y : head.y0;
  assign sk   = active ? k : 2'd0;

  // the next column in the same row only needs its right-hand column read
  assign fast = (sk == 2'd0) && prev_valid && (sy == prev_y) &&
                ({1'b0, sx} == {1'b0, prev_x} + 1'b1);
  assign fin       = fast || (sk == 2'd2);
  assign credit_ok = (ocnt <= (OPW+1)'(CREDIT_MAX));
  assign go        = have && credit_ok;
  assign q_pop     = go && !active;
  assign last_job  = (sx == src.x1) && (sy == src.y1);
  assign xl        = (sx == '0) ? '0 : sx - 1'b1;
  assign xr        = (sx == w_m1) ? sx : sx + 1'b1;

  always_comb begin
    raddr = xr;
    if (!fast) begin
      unique case (sk)
        2'd0:    raddr = xl;
        2'd1:    raddr = sx;
        default: raddr = xr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      k          <= '0;
      prev_valid <= 1'b0;
    end else if (go) begin
      if (fin) begin
        k          <= '0;
        prev_valid <= 1'b1;
        prev_x     <= sx;
        prev_y     <= sy;
        active     <= !last_job;
        if (sx != src.x1) begin
          cur   <= src;
          cur_x <= sx + 1'b1;
          cur_y <= sy;
        end else begin
          cur   <= '{x0: src.x0, x1: src.x1, y0: src.y0, y1: src.y1,
                     slot: slot_inc(src.slot)};
          cur_x <= src.x0;
          cur_y <= sy + 1'b1;
        end
      end else begin
        cur    <= src;
        active <= 1'b1;
        k      <= sk + 1'b1;
        cur_x  <= sx;
        cur_y  <= sy;
      end
    end
  end

  // stage 1: tag travels alongside the line store read
  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
    end else begin
      t1.valid <= go;
    end
    t1.fin  <= fin;
    t1.last <= last_job;
    t1.x    <= sx;
    t1.y    <= sy;
    t1.sy   <= src.slot;
    t1.sm   <= (sy == '0) ? src.slot : slot_dec(src.slot);
    t1.sp   <= (sy == h_m1) ? src.slot : slot_inc(src.slot);
  end

  // stage 2: pick the three rows, sort the column per channel, shift window
  assign pm  = trio_t'(rdata[t1.sm]);
  assign pyv = trio_t'(rdata[t1.sy]);
  assign pp  = trio_t'(rdata[t1.sp]);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      nsort[ch] = sort3(pm[ch], pyv[ch], pp[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (t1.valid) begin
      for (int ch = 0; ch < 3; ch++) begin
        win[0][ch] <= win[1][ch];
        win[1][ch] <= win[2][ch];
        win[2][ch] <= nsort[ch];
      end
    end
    t2_last <= t1.last;
    t2_x    <= t1.x;
    t2_y    <= t1.y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_fin <= 1'b0;
    end else begin
      t2_fin <= t1.valid && t1.fin;
    end
  end

  // stage 3: median of nine from the sorted columns
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      med[ch] = med3(max2(max2(win[0][ch][0], win[1][ch][0]), win[2][ch][0]),
                     med3(win[0][ch][1], win[1][ch][1], win[2][ch][1]),
                     min2(min2(win[0][ch][2], win[1][ch][2]), win[2][ch][2]));
    end
  end

  // result queue
  assign ohead       = oq[orp];
  assign out_valid   = (ocnt != '0);
  assign opop        = out_valid && !out_stall;
  assign out_red     = ohead.r;
  assign out_green   = ohead.g;
  assign out_blue    = ohead.b;
  assign out_col     = ohead.col;
  assign out_row     = ohead.row;
  assign last_of_run = ohead.last;

  always_ff @(posedge clk) begin
    if (t2_fin) begin
      oq[owp] <= '{r: med[2], g: med[1], b: med[0], col: t2_x, row: t2_y, last: t2_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      if (t2_fin) owp <= owp + 1'b1;
      if (opop)   orp <= orp + 1'b1;
      ocnt <= ocnt + (OPW+1)'(t2_fin) - (OPW+1)'(opop);
    end
  end

endmodule
`default_nettype wire

### rtl/rgb_median_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_median_filter_core
// Streaming 3x3 per-channel median filter with replicated borders.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one item per clock while in_stall is low.
// Each item is written straight into a three-row line store (one RAM bank
// per row slot) and the run of results it releases is queued for the back
// end. The back end reads one window column (all three banks at once) per
// clock while its result queue has room: a result whose left neighbour in
// the same row was the previous result needs only its right-hand column
// read, any other result (first of a row, each row of a border burst) needs
// a full window reload. Results leave through an 8-entry queue, so input
// keeps flowing while the output stalls until the queues fill. At the first
// pixel of each row the input stalls until the back end has read all earlier
// window columns, which protects the row slot about to be overwritten. There
// is no clearing pass after reset. Writing either register restarts the
// frame; write only while the block is idle. pready is always high.
// ----------------------------------------------------------------------------
module rgb_median_filter_core import rgbmf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pix_t              in_red,
  input  wire pix_t              in_green,
  input  wire pix_t              in_blue,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pix_t                   out_red,
  output pix_t                   out_green,
  output pix_t                   out_blue,
  output logic      [COL_W-1:0]  out_col,
  output logic      [ROW_W-1:0]  out_row,
  output logic                   last_of_run
);

  logic                       q_push;
  desc_t                      q_desc;
  logic                       q_pop;
  desc_t                      q_head;
  logic                       q_full;
  logic                       q_empty;
  logic                       back_active;
  logic                       back_busy;
  logic [SPAN-1:0]            wr_en;
  logic [COL_W-1:0]           wr_addr;
  logic [RGB_W-1:0]           wr_data;
  logic [COL_W-1:0]           raddr;
  logic [SPAN-1:0][RGB_W-1:0] rdata;
  logic [COL_W-1:0]           w_m1;
  logic [ROW_W-1:0]           h_m1;

  assign pready    = 1'b1;
  assign back_busy = back_active || !q_empty;

  rgbmf_front u_front (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .in_valid, .in_stall, .in_red, .in_green, .in_blue,
    .q_full, .back_busy,
    .push (q_push), .push_desc (q_desc),
    .wr_en, .wr_addr, .wr_data, .w_m1, .h_m1
  );

  rgbmf_queue u_queue (
    .clk, .rst,
    .push (q_push), .push_desc (q_desc), .pop (q_pop),
    .head (q_head), .full (q_full), .empty (q_empty)
  );

  // line store: one bank per row slot, same column read from all banks
  for (genvar b = 0; b < SPAN; b++) begin : g_bank
    rgbmf_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clk,
      .we    (wr_en[b]),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (raddr),
      .rdata (rdata[b])
    );
  end

  rgbmf_back u_back (
    .clk, .rst,
    .q_empty, .head (q_head), .q_pop, .active (back_active),
    .w_m1, .h_m1, .raddr, .rdata,
    .out_valid, .out_stall, .out_red, .out_green, .out_blue,
    .out_col, .out_row, .last_of_run
  );

`ifndef SYNTHESIS
  // the run queue is never written when full
  a_q_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("run queue overflow");

  // the back end only takes a run that is there
  a_q_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("run queue underflow");

  // a row start is only written once the back end has drained
  a_row_start_idle: assert property (@(posedge clk) disable iff (rst)
    ((wr_en != '0) && (wr_addr == '0)) |-> !back_busy)
    else $error("row slot overwritten while back end busy");
`endif

endmodule
`default_nettype wire
